// ===== hdl/bitmap_set_with_count_core_macros.svh =====
// assertion helpers for the bitmap set block
// every property is sampled on i_clk and ignored while i_rst_n is low
`ifndef BITMAP_SET_WITH_COUNT_CORE_MACROS_SVH
`define BITMAP_SET_WITH_COUNT_CORE_MACROS_SVH

`define BSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// a stalled valid must stay up
`define BSC_ASSERT_HOLD(lbl, vld, rdy, msg) \
    `BSC_ASSERT(lbl, (vld && !rdy) |=> vld, msg)

`endif

// ===== hdl/bsc_pkg.sv =====
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CAPACITY_DEF  = 4096;
    localparam int ELEM_W        = 16;
    localparam int CMD_W         = 2;
    localparam int COUNT_W       = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

endpackage

// ===== hdl/bsc_channels.sv =====
`timescale 1ns / 1ps
interface bsc_cmd_if import bsc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [ELEM_W-1:0] element;

    modport source (output valid, command, element, input ready);
    modport sink (input valid, command, element, output ready);
endinterface

interface bsc_res_if import bsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               was_present;
    logic [COUNT_W-1:0] member_count;
    logic               out_of_range;

    modport source (output valid, was_present, member_count, out_of_range, input ready);
    modport sink (input valid, was_present, member_count, out_of_range, output ready);
endinterface

// ===== hdl/bitmap_set_with_count_core.sv =====
// add, remove, test: accepting cycle, index split and word read, then modify and write-back;
//   the result then loads, or waits in S_EMIT for a free output; no command taken meanwhile
// out of range: result loads via S_EMIT once the output is free; no command taken meanwhile
// clear: zeroes the ceil(CAPACITY / WORD_BITS) words, one per cycle, result via S_EMIT
// after reset the same sweep runs first and no command is taken until it ends
// results sit in an output register, so a command is taken while a result is still held
`timescale 1ns / 1ps
module bitmap_set_with_count_core import bsc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CAPACITY  = CAPACITY_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bsc_cmd_if.sink   i_cmd,
    bsc_res_if.source o_res
);

    localparam int WORD_COUNT = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int POS_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);
    localparam logic [ELEM_W:0]   CAP_LIM   = (ELEM_W + 1)'(CAPACITY);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SPLIT = 5'b00100,
        S_MOD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_clr_reply, n_clr_reply;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]   r_word, n_word;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_res_present, n_res_present;
    logic                r_res_oor, n_res_oor;

    logic                r_out_valid;
    logic                r_out_present;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_oor;

    logic                cmd_ready;
    logic                split_load;
    logic [ADDR_W-1:0]   split_word;
    logic [POS_W-1:0]    split_pos;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] bit_mask;
    logic                present;
    logic                out_free;
    logic                load_out;
    logic [COUNT_W+CNT_W-1:0] count_ext;

    bsc_split #(
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W),
        .POS_W     (POS_W)
    ) u_split (
        .i_clk     (i_clk),
        .i_load    (split_load),
        .i_element (i_cmd.element),
        .o_word    (split_word),
        .o_pos     (split_pos)
    );

    bsc_mem #(
        .DEPTH  (WORD_COUNT),
        .DATA_W (WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (split_word),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign bit_mask = WORD_BITS'(1) << r_pos;
    assign present  = mem_rdata[r_pos];

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_clr_addr    = r_clr_addr;
        n_clr_reply   = r_clr_reply;
        n_count       = r_count;
        n_word        = r_word;
        n_pos         = r_pos;
        n_res_present = r_res_present;
        n_res_oor     = r_res_oor;
        cmd_ready     = 1'b0;
        split_load    = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_word;
        mem_wdata     = mem_rdata;
        mem_re        = 1'b0;
        load_out      = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_count    = '0;
                    if (r_clr_reply) begin
                        n_clr_reply   = 1'b0;
                        n_res_present = 1'b0;
                        n_res_oor     = 1'b0;
                        n_state       = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.command;
                    if (i_cmd.command == CMD_CLEAR) begin
                        n_clr_reply = 1'b1;
                        n_state     = S_CLEAR;
                    end else if ({1'b0, i_cmd.element} >= CAP_LIM) begin
                        n_res_present = 1'b0;
                        n_res_oor     = 1'b1;
                        n_state       = S_EMIT;
                    end else begin
                        split_load = 1'b1;
                        n_state    = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                mem_re  = 1'b1;
                n_word  = split_word;
                n_pos   = split_pos;
                n_state = S_MOD;
            end
            S_MOD: begin
                // read data of this word is valid now; only this command touches it
                case (r_cmd)
                    CMD_ADD: begin
                        if (!present) begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata | bit_mask;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (present) begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~bit_mask;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_res_present = present;
                n_res_oor     = 1'b0;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // member_count shows the low bits of the count
    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_count     <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_word        <= n_word;
        r_pos         <= n_pos;
        r_res_present <= n_res_present;
        r_res_oor     <= n_res_oor;
        if (load_out) begin
            r_out_present <= n_res_present;
            r_out_count   <= count_ext[COUNT_W-1:0];
            r_out_oor     <= n_res_oor;
        end
    end

    assign i_cmd.ready        = cmd_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.was_present  = r_out_present;
    assign o_res.member_count = r_out_count;
    assign o_res.out_of_range = r_out_oor;

endmodule

// ===== hdl/bsc_split.sv =====
`timescale 1ns / 1ps
module bsc_split import bsc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ADDR_W    = 6,
    parameter int POS_W     = 6
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [ELEM_W-1:0] i_element,
    output logic [ADDR_W-1:0] o_word,
    output logic [POS_W-1:0]  o_pos
);

    // quotient by reciprocal multiply; the estimate is at most one low
    localparam int SHIFT  = 24;
    localparam int RECIP  = (1 << SHIFT) / WORD_BITS;
    localparam int PROD_W = ELEM_W + SHIFT;

    logic [ELEM_W-1:0] r_elem;
    logic [PROD_W-1:0] r_prod;
    logic [ELEM_W-1:0] q_est;
    logic [ELEM_W-1:0] r_raw;
    logic [ELEM_W-1:0] q_fix;
    logic [ELEM_W-1:0] rem_fix;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_elem <= i_element;
            r_prod <= PROD_W'(i_element) * PROD_W'(RECIP);
        end
    end

    always_comb begin
        q_est = r_prod[SHIFT +: ELEM_W];
        r_raw = r_elem - ELEM_W'(q_est * ELEM_W'(WORD_BITS));
        if (r_raw >= ELEM_W'(WORD_BITS)) begin
            q_fix   = q_est + ELEM_W'(1);
            rem_fix = r_raw - ELEM_W'(WORD_BITS);
        end else begin
            q_fix   = q_est;
            rem_fix = r_raw;
        end
    end

    assign o_word = ADDR_W'(q_fix);
    assign o_pos  = POS_W'(rem_fix);

endmodule

// ===== hdl/bsc_mem.sv =====
`timescale 1ns / 1ps
module bsc_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bsc_checker.sv =====
`timescale 1ns / 1ps
`include "bitmap_set_with_count_core_macros.svh"
module bsc_assert_checker import bsc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input t_cmd               i_cmd_command,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic               i_res_was_present,
    input logic [COUNT_W-1:0] i_res_member_count,
    input logic               i_res_out_of_range
);

    logic [1:0] r_pending;
    logic       r_last_clear;
    logic       cmd_acc;
    logic       res_acc;

    assign cmd_acc = i_cmd_valid && i_cmd_ready;
    assign res_acc = i_res_valid && i_res_ready;

    // transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_last_clear <= 1'b0;
        end else begin
            r_pending <= r_pending + {1'b0, cmd_acc} - {1'b0, res_acc};
            if (cmd_acc) begin
                r_last_clear <= (i_cmd_command == CMD_CLEAR);
            end
        end
    end

    `BSC_ASSERT(a_no_orphan_result, i_res_valid |-> (r_pending != 2'd0), "result with no command")
    `BSC_ASSERT(a_pending_bound, r_pending != 2'd3, "more than two transactions in flight")
    `BSC_ASSERT(a_range_not_present, (i_res_valid && i_res_out_of_range) |-> !i_res_was_present, "out of range result reports presence")
    `BSC_ASSERT(a_clear_zero, (i_res_valid && r_pending == 2'd1 && r_last_clear) |-> (i_res_member_count == '0 && !i_res_was_present && !i_res_out_of_range), "clear result not zero")
    `BSC_ASSERT_HOLD(a_res_hold, i_res_valid, i_res_ready, "result dropped while stalled")

endmodule

bind bitmap_set_with_count_core bsc_assert_checker u_bsc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_cmd_valid        (i_cmd.valid),
    .i_cmd_ready        (i_cmd.ready),
    .i_cmd_command      (i_cmd.command),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_was_present  (o_res.was_present),
    .i_res_member_count (o_res.member_count),
    .i_res_out_of_range (o_res.out_of_range)
);

// ===== dv/bsc_checker.sv =====
`timescale 1ns / 1ps
module bsc_checker import bsc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CAPACITY  = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bsc_cmd_if   i_cmd,
    bsc_res_if   i_res,
    output int   o_pending,
    output int   o_mismatches
);

    localparam int WORD_COUNT  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               was_present;
        logic [COUNT_W-1:0] member_count;
        logic               out_of_range;
    } t_reply;

    logic [WORD_BITS-1:0] member_words [WORD_COUNT];
    int unsigned          member_total = 0;
    t_reply               reply_q [$];
    int                   mismatch_cnt = 0;

    // updates the shadow bitmap and returns the reply the block owes for this command
    function automatic t_reply apply_command(t_cmd cmd, logic [ELEM_W-1:0] elem);
        t_reply      r;
        int unsigned word_idx;
        int unsigned bit_idx;
        logic        present;
        r = '0;
        if (cmd == CMD_CLEAR) begin
            foreach (member_words[w]) member_words[w] = '0;
            member_total = 0;
            return r;
        end
        if (32'(elem) >= CAPACITY) begin
            r.member_count = member_total[COUNT_W-1:0];
            r.out_of_range = 1'b1;
            return r;
        end
        word_idx = 32'(elem) / WORD_BITS;
        bit_idx  = 32'(elem) % WORD_BITS;
        present  = member_words[word_idx][bit_idx];
        if (cmd == CMD_ADD && !present) begin
            member_words[word_idx][bit_idx] = 1'b1;
            member_total++;
        end else if (cmd == CMD_REMOVE && present) begin
            member_words[word_idx][bit_idx] = 1'b0;
            member_total--;
        end
        r.was_present  = present;
        r.member_count = member_total[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            foreach (member_words[w]) member_words[w] = '0;
            member_total = 0;
            reply_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.was_present  = i_res.was_present;
                got.member_count = i_res.member_count;
                got.out_of_range = i_res.out_of_range;
                if (reply_q.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("%0t: unexpected result present=%b count=%0d oor=%b",
                                 $time, got.was_present, got.member_count, got.out_of_range);
                    mismatch_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.was_present !== want.was_present ||
                        got.member_count !== want.member_count ||
                        got.out_of_range !== want.out_of_range) begin
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("%0t: result mismatch exp present=%b count=%0d oor=%b, got present=%b count=%0d oor=%b",
                                     $time, want.was_present, want.member_count,
                                     want.out_of_range, got.was_present,
                                     got.member_count, got.out_of_range);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                reply_q.push_back(apply_command(i_cmd.command, i_cmd.element));
        end
        o_pending    <= reply_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import bsc_pkg::*;

    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 50;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bsc_cmd_if cmd_ch ();
    bsc_res_if res_ch ();

    int          pending_cnt;
    int          mismatch_cnt;
    bit          src_gaps;
    bit          sink_gaps;
    bit          sink_hold_req;
    int          idle_cycles = 0;
    int          cmd_seen [4];
    int          oor_seen = 0;
    int unsigned hot_word [3];

    bitmap_set_with_count_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bsc_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_pending    (pending_cnt),
        .o_mismatches (mismatch_cnt)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_cmd rand_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 42)
            return CMD_ADD;
        else if (r < 67)
            return CMD_REMOVE;
        else if (r < 97)
            return CMD_TEST;
        return CMD_CLEAR;
    endfunction

    // bias towards a few busy words so adds and removes hit set bits often
    function automatic logic [ELEM_W-1:0] rand_element();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ELEM_W'(hot_word[$urandom_range(0, 2)] * WORD_BITS_DEF
                           + $urandom_range(0, WORD_BITS_DEF - 1));
        else if (r < 88)
            return ELEM_W'($urandom_range(0, CAPACITY_DEF - 1));
        return ELEM_W'($urandom_range(CAPACITY_DEF, 65535));
    endfunction

    task automatic send_cmd(t_cmd cmd, logic [ELEM_W-1:0] elem);
        int gap;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.element <= elem;
        do @(posedge i_clk); while (!cmd_ch.ready);
        cmd_seen[int'(cmd)]++;
        if (cmd != CMD_CLEAR && 32'(elem) >= CAPACITY_DEF)
            oor_seen++;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    initial begin : sink_side
        int gap_left;
        gap_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                gap_left = LONG_HOLD;
            end else if (gap_left == 0 && sink_gaps) begin
                gap_left = pick_gap();
            end
            if (gap_left > 0) begin
                res_ch.ready <= 1'b0;
                gap_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int seg;
        int n;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_TEST;
        cmd_ch.element = '0;
        src_gaps       = 1'b0;
        sink_gaps      = 1'b0;
        sink_hold_req  = 1'b0;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, word edges, duplicates, absent removes, range and clear
        send_cmd(CMD_TEST,   16'd0);
        send_cmd(CMD_ADD,    16'd0);
        send_cmd(CMD_ADD,    16'd0);
        send_cmd(CMD_ADD,    16'd4095);
        send_cmd(CMD_ADD,    16'd63);
        send_cmd(CMD_ADD,    16'd64);
        send_cmd(CMD_TEST,   16'd63);
        send_cmd(CMD_TEST,   16'd65);
        send_cmd(CMD_REMOVE, 16'd65);
        send_cmd(CMD_REMOVE, 16'd63);
        send_cmd(CMD_ADD,    16'd4096);
        send_cmd(CMD_REMOVE, 16'hFFFF);
        send_cmd(CMD_TEST,   16'h8000);
        send_cmd(CMD_ADD,    16'h5555);
        send_cmd(CMD_TEST,   16'd4095);
        send_cmd(CMD_CLEAR,  16'hFFFF);
        send_cmd(CMD_TEST,   16'd0);
        send_cmd(CMD_ADD,    16'h0AAA);
        send_cmd(CMD_TEST,   16'h0555);
        send_cmd(CMD_CLEAR,  16'd0);
        send_cmd(CMD_REMOVE, 16'd4095);
        send_cmd(CMD_ADD,    16'd4094);
        drain_results();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            src_gaps  = (seg % 4) != 0 && seg != 3;
            sink_gaps = (seg % 3) != 1;
            foreach (hot_word[k]) hot_word[k] = $urandom_range(0, 63);
            // long result stall while commands keep coming, so the input backs up
            if (seg == 3)
                sink_hold_req = 1'b1;
            for (n = 0; n < SEG_ITEMS; n++)
                send_cmd(rand_cmd(), rand_element());
            if (seg == 5)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d add, %0d remove, %0d test and %0d clear commands, %0d beyond capacity",
                 cmd_seen[int'(CMD_ADD)], cmd_seen[int'(CMD_REMOVE)],
                 cmd_seen[int'(CMD_TEST)], cmd_seen[int'(CMD_CLEAR)], oor_seen);
        $display("with random gaps on both sides, a long result stall and drained pauses");
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
